// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg
// Types, constants and microcode ROM for the selective-ack receive window.
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int SEQ_W    = 31;
    localparam int SLOTS    = 32;
    localparam int IDX_W    = 5;
    localparam int WIN_W    = 6;
    localparam int CNT_W    = 2;
    localparam int MAX_RUNS = 3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd16;
    localparam logic [WIN_W-1:0] WINDOW_CAP   = 6'd32;

    localparam logic [1:0] OP_RECV    = 2'd0;
    localparam logic [1:0] OP_DELIVER = 2'd1;
    localparam logic [1:0] OP_ACK     = 2'd2;

    localparam logic [1:0] RS_STORED = 2'd0;
    localparam logic [1:0] RS_BEYOND = 2'd1;
    localparam logic [1:0] RS_OLD    = 2'd2;
    localparam logic [1:0] DS_DONE   = 2'd0;
    localparam logic [1:0] DS_NONE   = 2'd1;

    typedef enum logic [1:0] {
        KIND_RECV,
        KIND_DELIVER,
        KIND_ACK,
        KIND_RUN
    } t_kind;

    // microprogram addresses
    typedef enum logic [2:0] {
        P_FETCH,
        P_RECV,
        P_DLV_RD,
        P_DLV,
        P_ACK_INIT,
        P_ACK_EVAL,
        P_ACK_END,
        P_ACK_RUN
    } t_step;

    typedef enum logic [2:0] {
        E_NONE,
        E_RECV,
        E_DLV,
        E_HDR,
        E_RUN
    } t_emit;

    typedef enum logic [1:0] {
        S_HOLD,
        S_INIT,
        S_EVAL,
        S_CLOSE
    } t_scan;

    typedef enum logic [2:0] {
        J_GOTO,
        J_DISPATCH,
        J_SCAN,
        J_RUNS,
        J_MORE
    } t_jump;

    typedef struct packed {
        logic  accept;
        logic  rd_scan;
        t_emit emit;
        t_scan scan;
        t_jump jump;
        t_step target;
    } t_uop;

    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u = '{accept: 1'b1, rd_scan: 1'b0, emit: E_NONE, scan: S_HOLD,
              jump: J_DISPATCH, target: P_FETCH};
        case (step)
            P_FETCH: begin
                u = '{accept: 1'b1, rd_scan: 1'b0, emit: E_NONE, scan: S_HOLD,
                      jump: J_DISPATCH, target: P_FETCH};
            end
            P_RECV: begin
                u = '{accept: 1'b0, rd_scan: 1'b0, emit: E_RECV, scan: S_HOLD,
                      jump: J_GOTO, target: P_FETCH};
            end
            P_DLV_RD: begin
                u = '{accept: 1'b0, rd_scan: 1'b0, emit: E_NONE, scan: S_HOLD,
                      jump: J_GOTO, target: P_DLV};
            end
            P_DLV: begin
                u = '{accept: 1'b0, rd_scan: 1'b0, emit: E_DLV, scan: S_HOLD,
                      jump: J_GOTO, target: P_FETCH};
            end
            P_ACK_INIT: begin
                u = '{accept: 1'b0, rd_scan: 1'b1, emit: E_NONE, scan: S_INIT,
                      jump: J_SCAN, target: P_ACK_EVAL};
            end
            P_ACK_EVAL: begin
                u = '{accept: 1'b0, rd_scan: 1'b1, emit: E_NONE, scan: S_EVAL,
                      jump: J_SCAN, target: P_ACK_EVAL};
            end
            P_ACK_END: begin
                u = '{accept: 1'b0, rd_scan: 1'b0, emit: E_HDR, scan: S_CLOSE,
                      jump: J_RUNS, target: P_ACK_RUN};
            end
            P_ACK_RUN: begin
                u = '{accept: 1'b0, rd_scan: 1'b0, emit: E_RUN, scan: S_HOLD,
                      jump: J_MORE, target: P_ACK_RUN};
            end
            default: begin
                u = '{accept: 1'b1, rd_scan: 1'b0, emit: E_NONE, scan: S_HOLD,
                      jump: J_DISPATCH, target: P_FETCH};
            end
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/sack_receive_window.sv =====
// ----------------------------------------------------------------------------
// sack_receive_window
// Microcoded receive window: receive, in-order deliver and selective-ack scan.
// ----------------------------------------------------------------------------
// Steps, accept edge to result valid: receive via P_RECV; deliver via a tag
//   read in P_DLV_RD, then P_DLV; ack via P_ACK_INIT, P_ACK_EVAL over the slots
//   scanned, the header, then one run beat per cycle while the output is free.
//   One slot-tag read per cycle bounds the ack scan; items enter only in P_FETCH.
// Reset: base and scan start to 0, window to 16, all slot valid bits cleared
//   at once; no clearing pass.

module sack_receive_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [30:0] i_frag_sequence,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_status,
    output logic [30:0] o_seq_value,
    output logic [4:0]  o_run_offset,
    output logic [5:0]  o_run_length,
    output logic [1:0]  o_run_count,
    output logic        o_last
);

    localparam int SW = srw_pkg::SEQ_W;
    localparam int IW = srw_pkg::IDX_W;
    localparam int WW = srw_pkg::WIN_W;
    localparam int CW = srw_pkg::CNT_W;

    srw_pkg::t_step r_step;
    srw_pkg::t_step n_step;
    srw_pkg::t_uop  uop;

    logic [SW-1:0]  r_base;
    logic [IW-1:0]  r_scan_start;
    logic [WW-1:0]  r_window;
    logic [SW-1:0]  r_fseq;

    logic [SW-1:0]  r_tag [srw_pkg::SLOTS];
    logic [srw_pkg::SLOTS-1:0] r_tval;
    logic [SW-1:0]  r_rd_tag;
    logic           r_rd_val;
    logic [IW-1:0]  rd_addr;

    logic [WW-1:0]  r_i;
    logic [WW-1:0]  n_i;
    logic           r_open;
    logic [WW-1:0]  r_runlen;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_k;
    logic [IW-1:0]  r_offs [srw_pkg::MAX_RUNS];
    logic [WW-1:0]  r_lens [srw_pkg::MAX_RUNS];

    logic           r_out_valid;
    logic [1:0]     r_out_kind;
    logic [1:0]     r_out_status;
    logic [SW-1:0]  r_out_seq;
    logic [IW-1:0]  r_out_off;
    logic [WW-1:0]  r_out_len;
    logic [CW-1:0]  r_out_cnt;
    logic           r_out_last;

    logic [WW-1:0]  win;
    logic [SW:0]    win_end;
    logic [SW:0]    scan_seq;
    logic [1:0]     recv_status;
    logic           dlv_present;
    logic           scan_present;
    logic           brk;
    logic           in_fire;
    logic           out_free;
    logic           adv;
    logic           run_last;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign uop      = srw_pkg::ucode(r_step);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign run_last = (r_k == (r_count - 2'd1));

    always_comb begin
        if (uop.accept) begin
            adv = in_fire;
        end else if (uop.emit != srw_pkg::E_NONE) begin
            adv = out_free;
        end else begin
            adv = 1'b1;
        end
    end

    always_comb begin
        n_step = uop.target;
        case (uop.jump)
            srw_pkg::J_GOTO: begin
                n_step = uop.target;
            end
            srw_pkg::J_DISPATCH: begin
                case (i_opcode)
                    srw_pkg::OP_RECV:    n_step = srw_pkg::P_RECV;
                    srw_pkg::OP_DELIVER: n_step = srw_pkg::P_DLV_RD;
                    srw_pkg::OP_ACK:     n_step = srw_pkg::P_ACK_INIT;
                    default:             n_step = srw_pkg::P_FETCH;
                endcase
            end
            srw_pkg::J_SCAN: begin
                n_step = (brk || (n_i >= win)) ? srw_pkg::P_ACK_END : uop.target;
            end
            srw_pkg::J_RUNS: begin
                n_step = (r_count == '0) ? srw_pkg::P_FETCH : uop.target;
            end
            srw_pkg::J_MORE: begin
                n_step = run_last ? srw_pkg::P_FETCH : uop.target;
            end
            default: begin
                n_step = srw_pkg::P_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= srw_pkg::P_FETCH;
        end else if (adv) begin
            r_step <= n_step;
        end
    end

    assign o_in_ready = uop.accept;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign win      = (r_window > srw_pkg::WINDOW_CAP) ? srw_pkg::WINDOW_CAP : r_window;
    assign win_end  = {1'b0, r_base} + {{(SW+1-WW){1'b0}}, win};
    assign scan_seq = {1'b0, r_base} + {{(SW+1-WW){1'b0}}, r_i};

    always_comb begin
        if ({1'b0, r_fseq} >= win_end) begin
            recv_status = srw_pkg::RS_BEYOND;
        end else if (r_fseq < r_base) begin
            recv_status = srw_pkg::RS_OLD;
        end else begin
            recv_status = srw_pkg::RS_STORED;
        end
    end

    assign dlv_present  = (win != '0) && r_rd_val && (r_rd_tag == r_base);
    assign scan_present = r_rd_val && (r_rd_tag == scan_seq[SW-1:0]) && !scan_seq[SW];
    assign brk = (uop.scan == srw_pkg::S_EVAL) && !scan_present && r_open &&
                 (r_count >= CW'(srw_pkg::MAX_RUNS));

    always_comb begin
        case (uop.scan)
            srw_pkg::S_INIT: n_i = {1'b0, r_scan_start};
            srw_pkg::S_EVAL: n_i = brk ? r_i : (r_i + 6'd1);
            default:         n_i = r_i;
        endcase
    end

    assign rd_addr = uop.rd_scan ? (r_base[IW-1:0] + n_i[IW-1:0]) : r_base[IW-1:0];

    // slot tag store
    always_ff @(posedge i_clk) begin
        if (adv && (uop.emit == srw_pkg::E_RECV) && (recv_status == srw_pkg::RS_STORED)) begin
            r_tag[r_fseq[IW-1:0]] <= r_fseq;
        end
        r_rd_tag <= r_tag[rd_addr];
        r_rd_val <= r_tval[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tval <= '0;
        end else if (adv && (uop.emit == srw_pkg::E_RECV) &&
                     (recv_status == srw_pkg::RS_STORED)) begin
            r_tval[r_fseq[IW-1:0]] <= 1'b1;
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= srw_pkg::WINDOW_RESET;
            r_base       <= '0;
            r_scan_start <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (adv && (uop.emit == srw_pkg::E_DLV) && dlv_present) begin
                r_base <= r_base + 31'd1;
            end
            if (adv && (uop.scan == srw_pkg::S_CLOSE)) begin
                r_scan_start <= (r_i < win) ? r_i[IW-1:0] : 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fseq <= i_frag_sequence;
        end
    end

    // scan and run tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
        end else if (adv) begin
            case (uop.scan)
                srw_pkg::S_INIT:  r_open <= 1'b0;
                srw_pkg::S_EVAL:  r_open <= scan_present;
                srw_pkg::S_CLOSE: r_open <= 1'b0;
                default:          r_open <= r_open;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (uop.scan)
                srw_pkg::S_INIT: begin
                    r_i      <= n_i;
                    r_count  <= '0;
                    r_runlen <= '0;
                end
                srw_pkg::S_EVAL: begin
                    r_i <= n_i;
                    if (scan_present) begin
                        if (!r_open) begin
                            r_offs[r_count] <= r_i[IW-1:0];
                            r_runlen        <= 6'd1;
                            r_count         <= r_count + 2'd1;
                        end else begin
                            r_runlen <= r_runlen + 6'd1;
                        end
                    end else if (r_open) begin
                        r_lens[r_count - 2'd1] <= r_runlen;
                    end
                end
                srw_pkg::S_CLOSE: begin
                    if (r_open) begin
                        r_lens[r_count - 2'd1] <= r_runlen;
                    end
                    r_k <= '0;
                end
                default: begin
                    if (uop.emit == srw_pkg::E_RUN) begin
                        r_k <= r_k + 2'd1;
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && (uop.emit != srw_pkg::E_NONE)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            case (uop.emit)
                srw_pkg::E_RECV: begin
                    r_out_kind   <= srw_pkg::KIND_RECV;
                    r_out_status <= recv_status;
                    r_out_seq    <= r_fseq;
                    r_out_off    <= '0;
                    r_out_len    <= '0;
                    r_out_cnt    <= '0;
                    r_out_last   <= 1'b1;
                end
                srw_pkg::E_DLV: begin
                    r_out_kind   <= srw_pkg::KIND_DELIVER;
                    r_out_status <= dlv_present ? srw_pkg::DS_DONE : srw_pkg::DS_NONE;
                    r_out_seq    <= r_base;
                    r_out_off    <= '0;
                    r_out_len    <= '0;
                    r_out_cnt    <= '0;
                    r_out_last   <= 1'b1;
                end
                srw_pkg::E_HDR: begin
                    r_out_kind   <= srw_pkg::KIND_ACK;
                    r_out_status <= '0;
                    r_out_seq    <= r_base;
                    r_out_off    <= '0;
                    r_out_len    <= '0;
                    r_out_cnt    <= r_count;
                    r_out_last   <= (r_count == '0);
                end
                srw_pkg::E_RUN: begin
                    r_out_kind   <= srw_pkg::KIND_RUN;
                    r_out_status <= '0;
                    r_out_seq    <= '0;
                    r_out_off    <= r_offs[r_k];
                    r_out_len    <= r_lens[r_k];
                    r_out_cnt    <= '0;
                    r_out_last   <= run_last;
                end
                default: begin
                    r_out_kind <= r_out_kind;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_status      = r_out_status;
    assign o_seq_value   = r_out_seq;
    assign o_run_offset  = r_out_off;
    assign o_run_length  = r_out_len;
    assign o_run_count   = r_out_cnt;
    assign o_last        = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `SRW_ASSERT_IMPLY(a_scan_in_window, r_step == srw_pkg::P_ACK_EVAL, r_i < win, "scan past window")
    `SRW_ASSERT_IMPLY(a_open_has_run, r_open, r_count != '0, "open run without count")
    `SRW_ASSERT_IMPLY(a_run_index, r_step == srw_pkg::P_ACK_RUN, r_k < r_count, "run beat beyond count")
    `SRW_ASSERT_NEXT(a_base_step, (r_step == srw_pkg::P_DLV) && adv && dlv_present, r_base == $past(r_base) + 31'd1, "base not advanced")

endmodule
